// ===== hw/rtl/usbpd_pkg.sv =====
// Package for the USB PD source policy engine.
// Holds event, message and state codes plus register defaults; no dependencies.
package usbpd_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned RetryW = 6;
  localparam int unsigned MsW = 10;

  localparam logic [MsW-1:0]    DefSrcCapPeriod = 10'd200;
  localparam logic [MsW-1:0]    DefRespTimeout  = 10'd30;
  localparam logic [MsW-1:0]    DefSrcOnTimeout = 10'd480;
  localparam logic [MsW-1:0]    DefSrcOffTimeout = 10'd750;
  localparam logic [MsW-1:0]    DefVbusPoll     = 10'd40;
  localparam logic [RetryW-1:0] DefMaxRetries   = 6'd50;

  typedef enum logic [2:0] {
    CfgSrcCap  = 3'd0,
    CfgResp    = 3'd1,
    CfgSrcOn   = 3'd2,
    CfgSrcOff  = 3'd3,
    CfgVbus    = 3'd4,
    CfgRetries = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    EvTick = 4'd0, EvStart = 4'd1, EvStop = 4'd2, EvGoodCrc = 4'd3,
    EvRequest = 4'd4, EvPrSwap = 4'd5, EvAccept = 4'd6, EvReject = 4'd7,
    EvPsRdy = 4'd8, EvSnkCap = 4'd9, EvDrSwap = 4'd10, EvHardReset = 4'd11,
    EvSendPr = 4'd12, EvSendDr = 4'd13, EvRsv14 = 4'd14, EvRsv15 = 4'd15
  } ev_e;

  localparam logic [3:0] MsgNone = 4'd0;
  localparam logic [3:0] MsgSrcCap = 4'd1;
  localparam logic [3:0] MsgAccept = 4'd2;
  localparam logic [3:0] MsgReject = 4'd3;
  localparam logic [3:0] MsgPsRdy = 4'd4;
  localparam logic [3:0] MsgGetSnk = 4'd5;
  localparam logic [3:0] MsgPrSwap = 4'd6;
  localparam logic [3:0] MsgDrSwap = 4'd7;
  localparam logic [3:0] MsgHardRst = 4'd8;

  localparam logic [1:0] PrNone = 2'd0;
  localparam logic [1:0] PrBegin = 2'd1;
  localparam logic [1:0] PrSource = 2'd2;
  localparam logic [1:0] PrSink = 2'd3;

  localparam logic [1:0] DrNone = 2'd0;
  localparam logic [1:0] DrUfp = 2'd1;
  localparam logic [1:0] DrDfp = 2'd2;

  localparam logic [1:0] StsUnknown = 2'd0;
  localparam logic [1:0] StsRunning = 2'd1;
  localparam logic [1:0] StsSuccess = 2'd2;
  localparam logic [1:0] StsFail = 2'd3;

  localparam logic [4:0] StNone = 5'd0;
  localparam logic [4:0] StCapSent = 5'd1;
  localparam logic [4:0] StCapGcrc = 5'd2;
  localparam logic [4:0] StAccSent = 5'd3;
  localparam logic [4:0] StRdySent = 5'd4;
  localparam logic [4:0] StReady = 5'd5;
  localparam logic [4:0] StFailed = 5'd6;
  localparam logic [4:0] StGetSnk = 5'd7;
  localparam logic [4:0] StPrSent = 5'd8;
  localparam logic [4:0] StPrAcc = 5'd9;
  localparam logic [4:0] StPrToOff = 5'd10;
  localparam logic [4:0] StPrSrcOff = 5'd11;
  localparam logic [4:0] StDrSentUfp = 5'd12;
  localparam logic [4:0] StDrSentDfp = 5'd13;
  localparam logic [4:0] StDrAccUfp = 5'd14;
  localparam logic [4:0] StDrAccDfp = 5'd15;
  localparam logic [4:0] StSink = 5'd16;

  function automatic logic [TimerW-1:0] load_ms(input logic [MsW-1:0] v);
    logic [TimerW-1:0] r;
    r = {{(TimerW-MsW){1'b0}}, v};
    if (v == '0) r = TimerW'(1);
    return r;
  endfunction

endpackage

// ===== hw/rtl/usb_pd_source_policy_fsm.sv =====
// USB PD source policy engine top level: handshake, config registers, state, next-state logic.
// Depends on usbpd_pkg.
// Result valid is registered, rising in the cycle after accept. Throughput: one request per
// cycle while out_ready_i is high; the result register is refilled in the cycle it is taken.
// Reset: asynchronous active low; state offline, timers idle, config at defaults,
// partner caps report dual data and dual power.
module usb_pd_source_policy_fsm (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] req_type_i,
  input  logic       vbus_present_i,
  input  logic [1:0] cur_drole_i,
  input  logic       is_source_role_i,
  input  logic       role_ok_i,
  input  logic       cap_fixed_supply_i,
  input  logic       cap_dual_power_i,
  input  logic       cap_dual_data_i,
  input  logic       cap_ext_powered_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] send_msg_o,
  output logic [1:0] power_role_cmd_o,
  output logic [1:0] drole_cmd_o,
  output logic [1:0] policy_status_o,
  output logic       status_notify_o,
  output logic       switch_to_sink_o,
  output logic       event_error_o,
  output logic [4:0] engine_state_o,
  output logic       partner_dual_power_o,
  output logic       partner_dual_data_o,
  output logic       partner_ext_powered_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i
);

  localparam int unsigned TW = usbpd_pkg::TimerW;
  localparam int unsigned RW = usbpd_pkg::RetryW;

  logic [9:0] src_cap_q, resp_q, src_on_q, src_off_q, vbus_poll_q;
  logic [RW-1:0] max_ret_q;

  logic [4:0] st_q, st_d;
  logic online_q, online_d;
  logic [1:0] sts_q, sts_d;
  logic [TW-1:0] tmr_q, tmr_d;
  logic [RW-1:0] cret_q, cret_d, vret_q, vret_d;
  logic caps_known_q, caps_known_d, contract_q, contract_d, swap_acc_q, swap_acc_d;
  logic [2:0] pcaps_q, pcaps_d;

  logic [3:0] msg_d;
  logic [1:0] prole_d, drole_d;
  logic notify_d, sink_d, err_d;

  logic [3:0] msg_q;
  logic [1:0] prole_q, drole_q;
  logic notify_q, sink_q, err_q;
  logic ovalid_q;

  logic fire;
  logic [TW-1:0] tdec;
  logic [RW-1:0] cret_inc;
  logic dr_ok;

  assign in_ready_o = !ovalid_q || out_ready_i;
  assign fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cap_q <= usbpd_pkg::DefSrcCapPeriod;
      resp_q <= usbpd_pkg::DefRespTimeout;
      src_on_q <= usbpd_pkg::DefSrcOnTimeout;
      src_off_q <= usbpd_pkg::DefSrcOffTimeout;
      vbus_poll_q <= usbpd_pkg::DefVbusPoll;
      max_ret_q <= usbpd_pkg::DefMaxRetries;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        usbpd_pkg::CfgSrcCap:  src_cap_q <= cfg_data_i;
        usbpd_pkg::CfgResp:    resp_q <= cfg_data_i;
        usbpd_pkg::CfgSrcOn:   src_on_q <= cfg_data_i;
        usbpd_pkg::CfgSrcOff:  src_off_q <= cfg_data_i;
        usbpd_pkg::CfgVbus:    vbus_poll_q <= cfg_data_i;
        usbpd_pkg::CfgRetries: max_ret_q <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q; online_d = online_q; sts_d = sts_q; tmr_d = tmr_q;
    cret_d = cret_q; vret_d = vret_q; caps_known_d = caps_known_q;
    contract_d = contract_q; swap_acc_d = swap_acc_q; pcaps_d = pcaps_q;
    msg_d = usbpd_pkg::MsgNone; prole_d = usbpd_pkg::PrNone;
    drole_d = usbpd_pkg::DrNone; notify_d = 1'b0; sink_d = 1'b0; err_d = 1'b0;
    tdec = tmr_q - TW'(1);
    cret_inc = (cret_q == {RW{1'b1}}) ? cret_q : cret_q + RW'(1);
    dr_ok = (st_q == usbpd_pkg::StReady) &&
            (cur_drole_i == usbpd_pkg::DrUfp || cur_drole_i == usbpd_pkg::DrDfp);

    if (req_type_i == usbpd_pkg::EvStart) begin
      online_d = 1'b1; sts_d = usbpd_pkg::StsRunning;
      st_d = usbpd_pkg::StNone; pcaps_d = 3'd3; tmr_d = TW'(1);
    end else if (req_type_i == usbpd_pkg::EvStop) begin
      online_d = 1'b0; sts_d = usbpd_pkg::StsUnknown; st_d = usbpd_pkg::StNone;
      tmr_d = '0; cret_d = '0; vret_d = '0; caps_known_d = 1'b0;
      contract_d = 1'b0; swap_acc_d = 1'b0; pcaps_d = 3'd0;
    end else if (!online_q) begin
      err_d = (req_type_i != usbpd_pkg::EvTick);
    end else begin
      case (req_type_i)
        usbpd_pkg::EvTick: begin
          if (st_q == usbpd_pkg::StPrToOff && !vbus_present_i) begin
            st_d = usbpd_pkg::StPrSrcOff; msg_d = usbpd_pkg::MsgPsRdy; tmr_d = '0;
          end else if (tmr_q != '0) begin
            tmr_d = tdec;
            if (tdec == '0) begin
              case (st_q)
                usbpd_pkg::StNone, usbpd_pkg::StCapSent, usbpd_pkg::StCapGcrc,
                usbpd_pkg::StAccSent, usbpd_pkg::StRdySent: begin
                  if (!contract_q) begin
                    if (!vbus_present_i) begin
                      if (vret_q < max_ret_q) begin
                        tmr_d = usbpd_pkg::load_ms(vbus_poll_q);
                        vret_d = vret_q + RW'(1);
                      end
                    end else begin
                      msg_d = usbpd_pkg::MsgSrcCap;
                      cret_d = cret_inc;
                      if (cret_inc < max_ret_q) begin
                        st_d = usbpd_pkg::StCapSent;
                        tmr_d = usbpd_pkg::load_ms(src_cap_q);
                      end else begin
                        st_d = usbpd_pkg::StFailed; sts_d = usbpd_pkg::StsFail;
                        notify_d = 1'b1;
                      end
                    end
                  end
                end
                usbpd_pkg::StReady: begin
                  if (!caps_known_q) begin
                    msg_d = usbpd_pkg::MsgGetSnk; cret_d = cret_inc;
                    st_d = usbpd_pkg::StGetSnk; tmr_d = usbpd_pkg::load_ms(resp_q);
                  end
                end
                usbpd_pkg::StGetSnk: begin
                  st_d = usbpd_pkg::StReady;
                  if (cret_q < max_ret_q) tmr_d = TW'(1);
                  else begin
                    cret_d = '0; sts_d = usbpd_pkg::StsSuccess; notify_d = 1'b1;
                  end
                end
                usbpd_pkg::StPrSent, usbpd_pkg::StDrSentUfp,
                usbpd_pkg::StDrSentDfp: st_d = usbpd_pkg::StReady;
                usbpd_pkg::StPrToOff: begin
                  prole_d = usbpd_pkg::PrSource; st_d = usbpd_pkg::StNone;
                  msg_d = usbpd_pkg::MsgHardRst; tmr_d = TW'(1);
                end
                usbpd_pkg::StPrSrcOff: begin
                  cret_d = '0; st_d = usbpd_pkg::StNone;
                  msg_d = usbpd_pkg::MsgHardRst; tmr_d = TW'(1);
                end
                usbpd_pkg::StDrAccUfp, usbpd_pkg::StDrAccDfp: begin
                  pcaps_d = 3'd3; st_d = usbpd_pkg::StNone;
                  msg_d = usbpd_pkg::MsgHardRst; tmr_d = TW'(1);
                end
                default: ;
              endcase
            end
          end
        end
        usbpd_pkg::EvGoodCrc: begin
          case (st_q)
            usbpd_pkg::StCapSent: st_d = usbpd_pkg::StCapGcrc;
            usbpd_pkg::StAccSent: begin
              msg_d = usbpd_pkg::MsgPsRdy; st_d = usbpd_pkg::StRdySent;
            end
            usbpd_pkg::StRdySent: begin
              st_d = usbpd_pkg::StReady; sts_d = usbpd_pkg::StsSuccess;
              cret_d = '0; contract_d = 1'b1; tmr_d = TW'(1);
            end
            usbpd_pkg::StPrAcc: begin
              prole_d = usbpd_pkg::PrBegin;
              if (!role_ok_i) begin
                st_d = usbpd_pkg::StNone; msg_d = usbpd_pkg::MsgHardRst; tmr_d = TW'(1);
              end else if (!vbus_present_i) begin
                st_d = usbpd_pkg::StPrSrcOff; msg_d = usbpd_pkg::MsgPsRdy; tmr_d = '0;
              end else begin
                st_d = usbpd_pkg::StPrToOff; tmr_d = usbpd_pkg::load_ms(src_off_q);
              end
            end
            usbpd_pkg::StPrSent: tmr_d = usbpd_pkg::load_ms(resp_q);
            usbpd_pkg::StPrSrcOff: tmr_d = usbpd_pkg::load_ms(src_on_q);
            usbpd_pkg::StDrAccUfp, usbpd_pkg::StDrAccDfp: begin
              drole_d = (st_q == usbpd_pkg::StDrAccUfp) ? usbpd_pkg::DrUfp
                                                         : usbpd_pkg::DrDfp;
              if (!role_ok_i) begin
                pcaps_d = 3'd3; st_d = usbpd_pkg::StNone;
                msg_d = usbpd_pkg::MsgHardRst; tmr_d = TW'(1);
              end else begin
                st_d = usbpd_pkg::StReady; tmr_d = '0;
              end
            end
            default: err_d = 1'b1;
          endcase
        end
        usbpd_pkg::EvRequest: begin
          if (st_q == usbpd_pkg::StCapSent || st_q == usbpd_pkg::StCapGcrc) begin
            msg_d = usbpd_pkg::MsgAccept; st_d = usbpd_pkg::StAccSent;
          end else err_d = 1'b1;
        end
        usbpd_pkg::EvPrSwap: begin
          if (is_source_role_i) begin
            st_d = usbpd_pkg::StPrAcc; sts_d = usbpd_pkg::StsRunning;
            msg_d = usbpd_pkg::MsgAccept;
          end else err_d = 1'b1;
        end
        usbpd_pkg::EvAccept, usbpd_pkg::EvReject: begin
          if (st_q == usbpd_pkg::StPrSent || st_q == usbpd_pkg::StDrSentUfp ||
              st_q == usbpd_pkg::StDrSentDfp) begin
            swap_acc_d = (req_type_i == usbpd_pkg::EvAccept);
            if (req_type_i == usbpd_pkg::EvReject) begin
              st_d = usbpd_pkg::StReady; tmr_d = '0;
            end else if (st_q == usbpd_pkg::StPrSent) begin
              prole_d = usbpd_pkg::PrBegin;
              if (!role_ok_i) begin
                st_d = usbpd_pkg::StNone; msg_d = usbpd_pkg::MsgHardRst; tmr_d = TW'(1);
              end else if (!vbus_present_i) begin
                st_d = usbpd_pkg::StPrSrcOff; msg_d = usbpd_pkg::MsgPsRdy; tmr_d = '0;
              end else begin
                st_d = usbpd_pkg::StPrToOff; tmr_d = usbpd_pkg::load_ms(src_off_q);
              end
            end else begin
              drole_d = (st_q == usbpd_pkg::StDrSentUfp) ? usbpd_pkg::DrUfp
                                                          : usbpd_pkg::DrDfp;
              if (!role_ok_i) begin
                pcaps_d = 3'd3; st_d = usbpd_pkg::StNone;
                msg_d = usbpd_pkg::MsgHardRst; tmr_d = TW'(1);
              end else begin
                st_d = usbpd_pkg::StReady; tmr_d = '0;
              end
            end
          end
        end
        usbpd_pkg::EvPsRdy: begin
          if (st_q == usbpd_pkg::StPrSrcOff) begin
            prole_d = usbpd_pkg::PrSink; sink_d = 1'b1;
            st_d = usbpd_pkg::StSink; tmr_d = '0;
          end
        end
        usbpd_pkg::EvSnkCap: begin
          if (st_q == usbpd_pkg::StGetSnk) begin
            st_d = usbpd_pkg::StReady; caps_known_d = 1'b1; tmr_d = '0;
            sts_d = usbpd_pkg::StsSuccess; notify_d = 1'b1;
            if (cap_fixed_supply_i)
              pcaps_d = {cap_ext_powered_i, cap_dual_power_i, cap_dual_data_i};
          end
        end
        usbpd_pkg::EvDrSwap: begin
          if (!dr_ok) msg_d = usbpd_pkg::MsgReject;
          else begin
            st_d = (cur_drole_i == usbpd_pkg::DrDfp) ? usbpd_pkg::StDrAccUfp
                                                     : usbpd_pkg::StDrAccDfp;
            sts_d = usbpd_pkg::StsRunning; msg_d = usbpd_pkg::MsgAccept;
            tmr_d = usbpd_pkg::load_ms(resp_q);
          end
        end
        usbpd_pkg::EvHardReset: begin
          st_d = usbpd_pkg::StNone; pcaps_d = 3'd3;
        end
        usbpd_pkg::EvSendPr: begin
          if (pcaps_q[1] && st_q == usbpd_pkg::StReady) begin
            st_d = usbpd_pkg::StPrSent; sts_d = usbpd_pkg::StsRunning;
            msg_d = usbpd_pkg::MsgPrSwap; tmr_d = '0;
          end
        end
        usbpd_pkg::EvSendDr: begin
          if (!dr_ok) err_d = 1'b1;
          else begin
            st_d = (cur_drole_i == usbpd_pkg::DrDfp) ? usbpd_pkg::StDrSentUfp
                                                     : usbpd_pkg::StDrSentDfp;
            sts_d = usbpd_pkg::StsRunning; msg_d = usbpd_pkg::MsgDrSwap;
            tmr_d = usbpd_pkg::load_ms(resp_q);
          end
        end
        default: err_d = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= usbpd_pkg::StNone; online_q <= 1'b0; sts_q <= usbpd_pkg::StsUnknown;
      tmr_q <= '0; cret_q <= '0; vret_q <= '0; caps_known_q <= 1'b0;
      contract_q <= 1'b0; swap_acc_q <= 1'b0; pcaps_q <= 3'd3;
      ovalid_q <= 1'b0;
    end else begin
      if (fire) begin
        st_q <= st_d; online_q <= online_d; sts_q <= sts_d; tmr_q <= tmr_d;
        cret_q <= cret_d; vret_q <= vret_d; caps_known_q <= caps_known_d;
        contract_q <= contract_d; swap_acc_q <= swap_acc_d; pcaps_q <= pcaps_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // result payload follows the state registers
  always_ff @(posedge clk_i) begin
    if (fire) begin
      msg_q <= msg_d; prole_q <= prole_d; drole_q <= drole_d;
      notify_q <= notify_d; sink_q <= sink_d; err_q <= err_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign send_msg_o = msg_q;
  assign power_role_cmd_o = prole_q;
  assign drole_cmd_o = drole_q;
  assign policy_status_o = sts_q;
  assign status_notify_o = notify_q;
  assign switch_to_sink_o = sink_q;
  assign event_error_o = err_q;
  assign engine_state_o = st_q;
  assign partner_dual_data_o = pcaps_q[0];
  assign partner_dual_power_o = pcaps_q[1];
  assign partner_ext_powered_o = pcaps_q[2] & swap_acc_q | pcaps_q[2] & ~swap_acc_q;

endmodule

// ===== tb/sv/usb_pd_source_policy_fsm_tb.sv =====
// Testbench for usb_pd_source_policy_fsm: directed and guided-random requests with a
// cycle-free predictor in a small tracker class. Depends on usbpd_pkg and the RTL top.
`timescale 1ns / 1ps

module usb_pd_source_policy_fsm_tb;

  typedef struct {
    usbpd_pkg::ev_e ev;
    bit             vbus;
    logic [1:0]     role;
    bit             src;
    bit             ok;
    bit             fixed;
    bit             dpow;
    bit             ddat;
    bit             ext;
  } req_t;

  typedef struct {
    logic [3:0] msg;
    logic [1:0] prole;
    logic [1:0] drole;
    logic [1:0] sts;
    bit         notify;
    bit         to_sink;
    bit         err;
    logic [4:0] st;
    bit         pdp;
    bit         pdd;
    bit         pext;
  } res_t;

  class pd_policy_tracker;
    logic [9:0] cfg [6];
    logic [4:0] st;
    bit         online;
    logic [1:0] sts;
    int         tmr;
    int         cmd_try;
    int         vbus_try;
    bit         caps_known;
    bit         contract;
    bit         swap_acc;
    logic [2:0] pcaps;
    res_t       expected_results[$];
    int         fails;
    int         checked;
    req_t       cur;
    res_t       o;

    function new();
      cfg[usbpd_pkg::CfgSrcCap]  = usbpd_pkg::DefSrcCapPeriod;
      cfg[usbpd_pkg::CfgResp]    = usbpd_pkg::DefRespTimeout;
      cfg[usbpd_pkg::CfgSrcOn]   = usbpd_pkg::DefSrcOnTimeout;
      cfg[usbpd_pkg::CfgSrcOff]  = usbpd_pkg::DefSrcOffTimeout;
      cfg[usbpd_pkg::CfgVbus]    = usbpd_pkg::DefVbusPoll;
      cfg[usbpd_pkg::CfgRetries] = 10'(usbpd_pkg::DefMaxRetries);
      st = usbpd_pkg::StNone; online = 0; sts = usbpd_pkg::StsUnknown; tmr = 0;
      cmd_try = 0; vbus_try = 0; caps_known = 0; contract = 0; swap_acc = 0;
      pcaps = 3'b011; fails = 0; checked = 0;
    endfunction

    function void write_cfg(usbpd_pkg::cfg_idx_e i, logic [9:0] v);
      cfg[i] = (i == usbpd_pkg::CfgRetries) ? {4'd0, v[5:0]} : v;
    endfunction

    function int arm(logic [9:0] v);
      return (v == 0) ? 1 : int'(v);
    endfunction

    function void bump();
      if (cmd_try < 63) cmd_try++;
    endfunction

    function void restart_hr();
      st = usbpd_pkg::StNone;
      o.msg = usbpd_pkg::MsgHardRst;
      tmr = 1;
    endfunction

    function void begin_caps();
      if (contract) return;
      if (!cur.vbus) begin
        if (vbus_try < int'(cfg[usbpd_pkg::CfgRetries])) begin
          tmr = arm(cfg[usbpd_pkg::CfgVbus]);
          vbus_try++;
        end
        return;
      end
      o.msg = usbpd_pkg::MsgSrcCap;
      st = usbpd_pkg::StCapSent;
      bump();
      if (cmd_try < int'(cfg[usbpd_pkg::CfgRetries])) tmr = arm(cfg[usbpd_pkg::CfgSrcCap]);
      else begin
        st = usbpd_pkg::StFailed;
        sts = usbpd_pkg::StsFail;
        o.notify = 1;
      end
    endfunction

    function void enter_off();
      st = usbpd_pkg::StPrToOff;
      o.prole = usbpd_pkg::PrBegin;
      if (!cur.ok) begin
        restart_hr();
        return;
      end
      if (!cur.vbus) begin
        st = usbpd_pkg::StPrSrcOff;
        o.msg = usbpd_pkg::MsgPsRdy;
        tmr = 0;
      end else tmr = arm(cfg[usbpd_pkg::CfgSrcOff]);
    endfunction

    function void data_swap(bit to_ufp);
      o.drole = to_ufp ? usbpd_pkg::DrUfp : usbpd_pkg::DrDfp;
      if (!cur.ok) begin
        pcaps = 3'b011;
        restart_hr();
      end else begin
        st = usbpd_pkg::StReady;
        tmr = 0;
      end
    endfunction

    function void expire();
      case (st)
        usbpd_pkg::StNone, usbpd_pkg::StCapSent, usbpd_pkg::StCapGcrc,
        usbpd_pkg::StAccSent, usbpd_pkg::StRdySent: begin
          begin_caps();
        end
        usbpd_pkg::StReady: begin
          if (!caps_known) begin
            o.msg = usbpd_pkg::MsgGetSnk;
            bump();
            st = usbpd_pkg::StGetSnk;
            tmr = arm(cfg[usbpd_pkg::CfgResp]);
          end
        end
        usbpd_pkg::StGetSnk: begin
          st = usbpd_pkg::StReady;
          if (cmd_try < int'(cfg[usbpd_pkg::CfgRetries])) tmr = 1;
          else begin
            cmd_try = 0;
            sts = usbpd_pkg::StsSuccess;
            o.notify = 1;
          end
        end
        usbpd_pkg::StPrSent, usbpd_pkg::StDrSentUfp,
        usbpd_pkg::StDrSentDfp: st = usbpd_pkg::StReady;
        usbpd_pkg::StPrToOff: begin
          o.prole = usbpd_pkg::PrSource;
          restart_hr();
        end
        usbpd_pkg::StPrSrcOff: begin
          cmd_try = 0;
          restart_hr();
        end
        usbpd_pkg::StDrAccUfp, usbpd_pkg::StDrAccDfp: begin
          pcaps = 3'b011;
          restart_hr();
        end
        default: ;
      endcase
    endfunction

    function void on_tick();
      if (st == usbpd_pkg::StPrToOff && !cur.vbus) begin
        st = usbpd_pkg::StPrSrcOff;
        o.msg = usbpd_pkg::MsgPsRdy;
        tmr = 0;
        return;
      end
      if (tmr != 0) begin
        tmr--;
        if (tmr == 0) expire();
      end
    endfunction

    function void on_goodcrc();
      case (st)
        usbpd_pkg::StCapSent: st = usbpd_pkg::StCapGcrc;
        usbpd_pkg::StAccSent: begin
          o.msg = usbpd_pkg::MsgPsRdy;
          st = usbpd_pkg::StRdySent;
        end
        usbpd_pkg::StRdySent: begin
          st = usbpd_pkg::StReady;
          sts = usbpd_pkg::StsSuccess;
          cmd_try = 0;
          contract = 1;
          tmr = 1;
        end
        usbpd_pkg::StPrAcc:    enter_off();
        usbpd_pkg::StPrSent:   tmr = arm(cfg[usbpd_pkg::CfgResp]);
        usbpd_pkg::StPrSrcOff: tmr = arm(cfg[usbpd_pkg::CfgSrcOn]);
        usbpd_pkg::StDrAccUfp: data_swap(1);
        usbpd_pkg::StDrAccDfp: data_swap(0);
        default:               o.err = 1;
      endcase
    endfunction

    function void on_answer(bit acc);
      logic [4:0] s;
      s = st;
      if (s != usbpd_pkg::StPrSent && s != usbpd_pkg::StDrSentUfp &&
          s != usbpd_pkg::StDrSentDfp) return;
      swap_acc = acc;
      if (!acc) begin
        st = usbpd_pkg::StReady;
        tmr = 0;
      end else if (s == usbpd_pkg::StPrSent) enter_off();
      else data_swap(s == usbpd_pkg::StDrSentUfp);
    endfunction

    function bit dr_ok();
      return st == usbpd_pkg::StReady &&
             (cur.role == usbpd_pkg::DrUfp || cur.role == usbpd_pkg::DrDfp);
    endfunction

    function void note_request(req_t r);
      cur = r;
      o = '{msg: usbpd_pkg::MsgNone, prole: usbpd_pkg::PrNone, drole: usbpd_pkg::DrNone,
            sts: usbpd_pkg::StsUnknown, notify: 0, to_sink: 0, err: 0,
            st: usbpd_pkg::StNone, pdp: 0, pdd: 0, pext: 0};
      if (r.ev == usbpd_pkg::EvStart) begin
        online = 1;
        sts = usbpd_pkg::StsRunning;
        st = usbpd_pkg::StNone;
        pcaps = 3'b011;
        tmr = 1;
      end else if (r.ev == usbpd_pkg::EvStop) begin
        online = 0; sts = usbpd_pkg::StsUnknown; st = usbpd_pkg::StNone; tmr = 0;
        cmd_try = 0; vbus_try = 0; caps_known = 0; contract = 0; swap_acc = 0;
        pcaps = 3'b000;
      end else if (!online) begin
        if (r.ev != usbpd_pkg::EvTick) o.err = 1;
      end else begin
        case (r.ev)
          usbpd_pkg::EvTick:    on_tick();
          usbpd_pkg::EvGoodCrc: on_goodcrc();
          usbpd_pkg::EvRequest: begin
            if (st == usbpd_pkg::StCapSent || st == usbpd_pkg::StCapGcrc) begin
              o.msg = usbpd_pkg::MsgAccept;
              st = usbpd_pkg::StAccSent;
            end else o.err = 1;
          end
          usbpd_pkg::EvPrSwap: begin
            if (r.src) begin
              st = usbpd_pkg::StPrAcc;
              sts = usbpd_pkg::StsRunning;
              o.msg = usbpd_pkg::MsgAccept;
            end else o.err = 1;
          end
          usbpd_pkg::EvAccept: on_answer(1);
          usbpd_pkg::EvReject: on_answer(0);
          usbpd_pkg::EvPsRdy: begin
            if (st == usbpd_pkg::StPrSrcOff) begin
              o.prole = usbpd_pkg::PrSink;
              o.to_sink = 1;
              st = usbpd_pkg::StSink;
              tmr = 0;
            end
          end
          usbpd_pkg::EvSnkCap: begin
            if (st == usbpd_pkg::StGetSnk) begin
              st = usbpd_pkg::StReady;
              caps_known = 1;
              tmr = 0;
              sts = usbpd_pkg::StsSuccess;
              o.notify = 1;
              if (r.fixed) pcaps = {r.ext, r.dpow, r.ddat};
            end
          end
          usbpd_pkg::EvDrSwap: begin
            if (!dr_ok()) o.msg = usbpd_pkg::MsgReject;
            else begin
              st = (r.role == usbpd_pkg::DrDfp) ? usbpd_pkg::StDrAccUfp
                                                : usbpd_pkg::StDrAccDfp;
              sts = usbpd_pkg::StsRunning;
              o.msg = usbpd_pkg::MsgAccept;
              tmr = arm(cfg[usbpd_pkg::CfgResp]);
            end
          end
          usbpd_pkg::EvHardReset: begin
            st = usbpd_pkg::StNone;
            pcaps = 3'b011;
          end
          usbpd_pkg::EvSendPr: begin
            if (pcaps[1] && st == usbpd_pkg::StReady) begin
              st = usbpd_pkg::StPrSent;
              sts = usbpd_pkg::StsRunning;
              o.msg = usbpd_pkg::MsgPrSwap;
              tmr = 0;
            end
          end
          usbpd_pkg::EvSendDr: begin
            if (!dr_ok()) o.err = 1;
            else begin
              st = (r.role == usbpd_pkg::DrDfp) ? usbpd_pkg::StDrSentUfp
                                                : usbpd_pkg::StDrSentDfp;
              sts = usbpd_pkg::StsRunning;
              o.msg = usbpd_pkg::MsgDrSwap;
              tmr = arm(cfg[usbpd_pkg::CfgResp]);
            end
          end
          default: o.err = 1;
        endcase
      end
      o.sts  = sts;
      o.st   = st;
      o.pdp  = pcaps[1];
      o.pdd  = pcaps[0];
      o.pext = pcaps[2];
      expected_results.push_back(o);
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, got %0d", name, e, a);
        fails++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      cmp("send_msg", e.msg, got.msg);
      cmp("power_role_cmd", e.prole, got.prole);
      cmp("drole_cmd", e.drole, got.drole);
      cmp("policy_status", e.sts, got.sts);
      cmp("status_notify", e.notify, got.notify);
      cmp("switch_to_sink", e.to_sink, got.to_sink);
      cmp("event_error", e.err, got.err);
      cmp("engine_state", e.st, got.st);
      cmp("partner_dual_power", e.pdp, got.pdp);
      cmp("partner_dual_data", e.pdd, got.pdd);
      cmp("partner_ext_powered", e.pext, got.pext);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [3:0] req_type;
  logic       vbus_present;
  logic [1:0] cur_drole;
  logic       is_source_role;
  logic       role_ok;
  logic       cap_fixed_supply;
  logic       cap_dual_power;
  logic       cap_dual_data;
  logic       cap_ext_powered;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] send_msg;
  logic [1:0] power_role_cmd;
  logic [1:0] drole_cmd;
  logic [1:0] policy_status;
  logic       status_notify;
  logic       switch_to_sink;
  logic       event_error;
  logic [4:0] engine_state;
  logic       partner_dual_power;
  logic       partner_dual_data;
  logic       partner_ext_powered;
  logic       cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [9:0] cfg_data_i;

  pd_policy_tracker tracker;
  int snd_idle_pct;
  int rcv_idle_pct;
  bit hold_req;
  int sent;

  usb_pd_source_policy_fsm dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .vbus_present_i(vbus_present), .cur_drole_i(cur_drole),
    .is_source_role_i(is_source_role), .role_ok_i(role_ok),
    .cap_fixed_supply_i(cap_fixed_supply), .cap_dual_power_i(cap_dual_power),
    .cap_dual_data_i(cap_dual_data), .cap_ext_powered_i(cap_ext_powered),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .send_msg_o(send_msg), .power_role_cmd_o(power_role_cmd),
    .drole_cmd_o(drole_cmd), .policy_status_o(policy_status),
    .status_notify_o(status_notify), .switch_to_sink_o(switch_to_sink),
    .event_error_o(event_error), .engine_state_o(engine_state),
    .partner_dual_power_o(partner_dual_power), .partner_dual_data_o(partner_dual_data),
    .partner_ext_powered_o(partner_ext_powered),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready = 0;
        repeat (120) @(negedge clk_i);
        hold_req = 0;
      end
      out_ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    req_t r;
    res_t g;
    if (rst_ni && in_valid && in_ready) begin
      r.ev = usbpd_pkg::ev_e'(req_type); r.vbus = vbus_present; r.role = cur_drole;
      r.src = is_source_role; r.ok = role_ok; r.fixed = cap_fixed_supply;
      r.dpow = cap_dual_power; r.ddat = cap_dual_data; r.ext = cap_ext_powered;
      tracker.note_request(r);
    end
    if (rst_ni && out_valid && out_ready) begin
      g = '{msg: send_msg, prole: power_role_cmd, drole: drole_cmd,
            sts: policy_status, notify: status_notify, to_sink: switch_to_sink,
            err: event_error, st: engine_state, pdp: partner_dual_power,
            pdd: partner_dual_data, pext: partner_ext_powered};
      tracker.check_result(g);
    end
  end

  function automatic req_t mk(usbpd_pkg::ev_e ev, bit vbus = 1'b1,
                              logic [1:0] role = usbpd_pkg::DrDfp,
                              bit ok = 1'b1, bit src = 1'b1);
    req_t r;
    r = '{ev: ev, vbus: vbus, role: role, src: src, ok: ok,
          fixed: 0, dpow: 0, ddat: 0, ext: 0};
    return r;
  endfunction

  // mostly the event that moves the current state forward, otherwise noise
  function automatic req_t pick_req();
    req_t r;
    usbpd_pkg::ev_e e;
    r.vbus  = ($urandom_range(9) != 0);
    r.role  = 2'($urandom_range(2));
    r.src   = ($urandom_range(4) != 0);
    r.ok    = ($urandom_range(9) != 0);
    r.fixed = ($urandom_range(3) != 0);
    r.dpow  = 1'($urandom_range(1));
    r.ddat  = 1'($urandom_range(1));
    r.ext   = 1'($urandom_range(1));
    e = usbpd_pkg::EvTick;
    if ($urandom_range(99) < 25) begin
      e = ($urandom_range(40) == 0) ? usbpd_pkg::ev_e'($urandom_range(15))
                                     : usbpd_pkg::ev_e'($urandom_range(13));
    end else if (!tracker.online) begin
      e = usbpd_pkg::EvStart;
    end else begin
      case (tracker.st)
        usbpd_pkg::StCapSent:
          e = $urandom_range(1) ? usbpd_pkg::EvGoodCrc : usbpd_pkg::EvRequest;
        usbpd_pkg::StCapGcrc: e = usbpd_pkg::EvRequest;
        usbpd_pkg::StAccSent, usbpd_pkg::StRdySent, usbpd_pkg::StPrAcc,
        usbpd_pkg::StDrAccUfp, usbpd_pkg::StDrAccDfp:
          e = $urandom_range(3) ? usbpd_pkg::EvGoodCrc : usbpd_pkg::EvTick;
        usbpd_pkg::StReady: begin
          case ($urandom_range(5))
            0: e = usbpd_pkg::EvSendPr;
            1: e = usbpd_pkg::EvSendDr;
            2: e = usbpd_pkg::EvDrSwap;
            3: e = usbpd_pkg::EvPrSwap;
            default: e = usbpd_pkg::EvTick;
          endcase
        end
        usbpd_pkg::StFailed, usbpd_pkg::StSink:
          e = $urandom_range(1) ? usbpd_pkg::EvStart : usbpd_pkg::EvStop;
        usbpd_pkg::StGetSnk:
          e = $urandom_range(1) ? usbpd_pkg::EvSnkCap : usbpd_pkg::EvTick;
        usbpd_pkg::StPrSent: begin
          case ($urandom_range(3))
            0: e = usbpd_pkg::EvGoodCrc;
            1: e = usbpd_pkg::EvAccept;
            2: e = usbpd_pkg::EvReject;
            default: e = usbpd_pkg::EvTick;
          endcase
        end
        usbpd_pkg::StDrSentUfp, usbpd_pkg::StDrSentDfp: begin
          case ($urandom_range(2))
            0: e = usbpd_pkg::EvAccept;
            1: e = usbpd_pkg::EvReject;
            default: e = usbpd_pkg::EvTick;
          endcase
        end
        usbpd_pkg::StPrToOff: begin
          e = usbpd_pkg::EvTick;
          r.vbus = 1'($urandom_range(1));
        end
        usbpd_pkg::StPrSrcOff:
          e = $urandom_range(2) ? usbpd_pkg::EvPsRdy : usbpd_pkg::EvGoodCrc;
        default: e = usbpd_pkg::EvTick;
      endcase
    end
    r.ev = e;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(req_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 0;
      @(negedge clk_i);
    end
    req_type = r.ev; vbus_present = r.vbus; cur_drole = r.role;
    is_source_role = r.src; role_ok = r.ok; cap_fixed_supply = r.fixed;
    cap_dual_power = r.dpow; cap_dual_data = r.ddat; cap_ext_powered = r.ext;
    in_valid = 1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid = 0;
    while (tracker.expected_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_cfg(logic [9:0] v [6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i = 1;
      cfg_idx_i = 3'(i);
      cfg_data_i = v[i];
      tracker.write_cfg(usbpd_pkg::cfg_idx_e'(i), v[i]);
      @(negedge clk_i);
    end
    cfg_we_i = 0;
  endtask

  task automatic run_random(int n, int s_idle, int r_idle, bit squeeze);
    snd_idle_pct = s_idle;
    rcv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 3) hold_req = 1;
      if (squeeze && i == 2 * n / 3) drain();
      send_req(pick_req());
    end
    drain();
  endtask

  initial begin
    logic [9:0] v [6];
    req_t       d [$];
    req_t       r;
    tracker = new();
    in_valid = 0; out_ready = 0; hold_req = 0; sent = 0;
    req_type = usbpd_pkg::EvTick; vbus_present = 0; cur_drole = usbpd_pkg::DrNone;
    is_source_role = 0;
    role_ok = 0; cap_fixed_supply = 0; cap_dual_power = 0; cap_dual_data = 0;
    cap_ext_powered = 0; cfg_we_i = 0; cfg_idx_i = usbpd_pkg::CfgSrcCap; cfg_data_i = '0;
    snd_idle_pct = 0; rcv_idle_pct = 0;
    rst_ni = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // short timers for the directed walk through the main states
    v = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd3};
    set_cfg(v);
    d.push_back(mk(usbpd_pkg::EvTick));
    d.push_back(mk(usbpd_pkg::EvGoodCrc));
    d.push_back(mk(usbpd_pkg::EvRsv15));
    d.push_back(mk(usbpd_pkg::EvStart));
    d.push_back(mk(usbpd_pkg::EvTick, 1'b0));
    d.push_back(mk(usbpd_pkg::EvTick));
    d.push_back(mk(usbpd_pkg::EvTick));
    d.push_back(mk(usbpd_pkg::EvRequest));
    d.push_back(mk(usbpd_pkg::EvGoodCrc));
    d.push_back(mk(usbpd_pkg::EvGoodCrc));
    d.push_back(mk(usbpd_pkg::EvTick));
    r = mk(usbpd_pkg::EvSnkCap);
    r.fixed = 1; r.dpow = 1; r.ddat = 1; r.ext = 1;
    d.push_back(r);
    d.push_back(mk(usbpd_pkg::EvSendDr, 1'b1, usbpd_pkg::DrDfp));
    d.push_back(mk(usbpd_pkg::EvAccept));
    d.push_back(mk(usbpd_pkg::EvDrSwap, 1'b1, usbpd_pkg::DrUfp));
    d.push_back(mk(usbpd_pkg::EvGoodCrc, 1'b1, usbpd_pkg::DrUfp, 1'b0));
    d.push_back(mk(usbpd_pkg::EvHardReset));
    d.push_back(mk(usbpd_pkg::EvStop));
    d.push_back(mk(usbpd_pkg::EvStart));
    d.push_back(mk(usbpd_pkg::EvSendPr));
    d.push_back(mk(usbpd_pkg::EvPrSwap, 1'b1, usbpd_pkg::DrDfp, 1'b1, 1'b1));
    d.push_back(mk(usbpd_pkg::EvGoodCrc, 1'b0));
    d.push_back(mk(usbpd_pkg::EvPsRdy));
    d.push_back(mk(usbpd_pkg::EvRsv14));
    d.push_back(mk(usbpd_pkg::EvSendDr, 1'b1, usbpd_pkg::DrNone));
    foreach (d[i]) send_req(d[i]);
    drain();

    run_random(400, 13, 81, 0);
    for (int i = 0; i < 5; i++) v[i] = 10'($urandom_range(1, 10));
    v[5] = 10'($urandom_range(1, 8));
    set_cfg(v);
    run_random(400, 81, 13, 0);
    // zero timer values load as one; retry limit at its top
    v = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd63};
    set_cfg(v);
    run_random(400, 0, 0, 1);
    for (int i = 0; i < 5; i++) v[i] = 10'($urandom_range(1, 25));
    v[5] = 10'($urandom_range(0, 63));
    set_cfg(v);
    run_random(350, 0, 0, 0);
    v = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1};
    set_cfg(v);
    run_random(150, 0, 0, 0);

    repeat (5) @(negedge clk_i);
    $display("Covered %0d requests over five timer/retry settings, %0d results checked,",
             sent, tracker.checked);
    $display("with stalls on both sides, a long result back-pressure and a full drain.");
    if (tracker.fails == 0 && tracker.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/usbpd_pkg.sv
hw/rtl/usb_pd_source_policy_fsm.sv
tb/sv/usb_pd_source_policy_fsm_tb.sv
